/* rtl/sois_pkg.sv */
`timescale 1ns / 1ps

package sois_pkg;

  localparam int SampleBits   = 16;
  localparam int CoefBits     = 16;
  localparam int ChBits       = 1;
  localparam int Channels     = 2;
  localparam int AddrBits     = 1;
  localparam int CfgIndexBits = 2;
  localparam int FracBits     = 14;
  localparam int ProdBits     = SampleBits + CoefBits;
  localparam int SumBits      = ProdBits + 3;
  localparam int QBits        = SumBits - FracBits;

  typedef enum logic [CfgIndexBits-1:0] {
    CFG_COEF_A,
    CFG_COEF_B,
    CFG_COEF_C,
    CFG_COEF_D
  } cfg_index_t;

  typedef logic signed [SampleBits-1:0] sample_t;
  typedef logic signed [ProdBits-1:0]   prod_t;
  typedef logic [AddrBits-1:0]          addr_t;

  typedef struct packed {
    sample_t y1;
    sample_t y2;
    sample_t u1;
    sample_t u2;
  } hist_t;

  typedef struct packed {
    logic signed [CoefBits-1:0] a;
    logic signed [CoefBits-1:0] b;
    logic signed [CoefBits-1:0] c;
    logic signed [CoefBits-1:0] d;
  } coef_t;

  typedef struct packed {
    logic  en;
    addr_t addr;
  } hist_rd_t;

  typedef struct packed {
    logic  en;
    addr_t addr;
    hist_t data;
  } hist_wr_t;

endpackage

/* rtl/second_order_iir_section.sv */
`timescale 1ns / 1ps
// Second-order IIR section, one history per channel:
//   y = a*y[k-1] + b*y[k-2] + c*u[k] + d*u[k-2], Q2.14 coefficients,
//   rounded to nearest and saturated to a signed 16-bit sample.
// Input stream s_*: one request per sample, channel on s_tuser.
// Output stream m_*: one filtered sample per request, in request order.
// Config channel cfg_*: register index 0..3 = coef_a..coef_d, always ready
//   outside reset; write only while the filter is idle.
// Pipeline from input request to m_tvalid: history read, multiply, then
//   sum/round/saturate with write-back into the history memory.
// Requests on alternating channels overlap in the pipeline; a request on the
//   same channel waits until the previous one has been written back, set by the
//   read-modify-write loop through the history memory.
// Reset clears the coefficients and all channel histories (per-entry valid
//   bits, no clearing pass) and empties the pipeline; s_tready is low in reset.
// When m_tready is low the output register holds its sample; the two inner
//   stages still fill, then s_tready drops.
module second_order_iir_section
  import sois_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    s_tvalid,
  output logic                    s_tready,
  input  logic [SampleBits-1:0]   s_tdata,   // [15:0] sample_in
  input  logic [ChBits-1:0]       s_tuser,   // [0] channel_index
  output logic                    m_tvalid,
  input  logic                    m_tready,
  output logic [SampleBits-1:0]   m_tdata,   // [15:0] sample_out
  output logic [ChBits-1:0]       m_tuser,   // [0] channel_out
  input  logic                    cfg_valid,
  output logic                    cfg_ready,
  input  logic [CfgIndexBits-1:0] cfg_index,
  input  logic [CoefBits-1:0]     cfg_data
);

  coef_t    coef;
  hist_rd_t rd;
  hist_wr_t wr;
  hist_t    hist;
  sample_t  out_sample;

  assign cfg_ready = !rst;

  always_ff @(posedge clk) begin
    if (rst) begin
      coef <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index_t'(cfg_index))
        CFG_COEF_A: coef.a <= cfg_data;
        CFG_COEF_B: coef.b <= cfg_data;
        CFG_COEF_C: coef.c <= cfg_data;
        CFG_COEF_D: coef.d <= cfg_data;
        default:    coef   <= coef;
      endcase
    end
  end

  sois_hist_ram u_hist_ram (
    .clk     (clk),
    .rst     (rst),
    .rd      (rd),
    .rd_data (hist),
    .wr      (wr)
  );

  sois_datapath u_datapath (
    .clk        (clk),
    .rst        (rst),
    .coef       (coef),
    .in_valid   (s_tvalid),
    .in_ready   (s_tready),
    .in_ch      (s_tuser),
    .in_sample  (sample_t'(s_tdata)),
    .rd         (rd),
    .hist       (hist),
    .wr         (wr),
    .out_valid  (m_tvalid),
    .out_ready  (m_tready),
    .out_ch     (m_tuser),
    .out_sample (out_sample)
  );

  assign m_tdata = SampleBits'(out_sample);

endmodule

/* rtl/sois_hist_ram.sv */
`timescale 1ns / 1ps

module sois_hist_ram
  import sois_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  hist_rd_t rd,
  output hist_t    rd_data,
  input  hist_wr_t wr
);

  hist_t               mem [Channels];
  logic [Channels-1:0] vld;
  hist_t               rd_raw;
  logic                rd_vld;

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
    if (rd.en) begin
      rd_raw <= mem[rd.addr];
    end
  end

  // entries never written since reset read as zero history
  always_ff @(posedge clk) begin
    if (rst) begin
      vld    <= '0;
      rd_vld <= 1'b0;
    end else begin
      if (wr.en) begin
        vld[wr.addr] <= 1'b1;
      end
      if (rd.en) begin
        rd_vld <= vld[rd.addr];
      end
    end
  end

  assign rd_data = rd_vld ? rd_raw : '0;

endmodule

/* rtl/sois_datapath.sv */
`timescale 1ns / 1ps

module sois_datapath
  import sois_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  coef_t             coef,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [ChBits-1:0] in_ch,
  input  sample_t           in_sample,
  output hist_rd_t          rd,
  input  hist_t             hist,
  output hist_wr_t          wr,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [ChBits-1:0] out_ch,
  output sample_t           out_sample
);

  localparam logic signed [SumBits-1:0] RoundBias = SumBits'(1 << (FracBits - 1));
  localparam logic signed [QBits-1:0]   QMax = QBits'((1 << (SampleBits - 1)) - 1);
  localparam logic signed [QBits-1:0]   QMin = QBits'(-(1 << (SampleBits - 1)));
  localparam sample_t SampleMax = sample_t'((1 << (SampleBits - 1)) - 1);
  localparam sample_t SampleMin = sample_t'(-(1 << (SampleBits - 1)));

  logic              p1_valid;
  logic [ChBits-1:0] p1_ch;
  sample_t           p1_u;

  logic              p2_valid;
  logic [ChBits-1:0] p2_ch;
  sample_t           p2_u;
  sample_t           p2_y1;
  sample_t           p2_u1;
  prod_t             p2_pa;
  prod_t             p2_pb;
  prod_t             p2_pc;
  prod_t             p2_pd;

  logic              o_valid;
  logic [ChBits-1:0] o_ch;
  sample_t           o_y;

  logic o_free, p2_move, p2_free, p1_move, p1_free, hazard, accept;
  logic signed [SumBits-1:0] sum;
  logic signed [QBits-1:0]   q;
  sample_t                   y_sat;

  assign o_free  = !o_valid || out_ready;
  assign p2_move = p2_valid && o_free;
  assign p2_free = !p2_valid || p2_move;
  assign p1_move = p1_valid && p2_free;
  assign p1_free = !p1_valid || p1_move;

  // same channel still in flight: wait until its history is written back
  assign hazard   = (p1_valid && p1_ch == in_ch) || (p2_valid && p2_ch == in_ch);
  assign in_ready = !rst && p1_free && !hazard;
  assign accept   = in_valid && in_ready;

  assign rd.en   = accept;
  assign rd.addr = addr_t'(in_ch);

  always_comb begin
    sum = SumBits'(p2_pa) + SumBits'(p2_pb) + SumBits'(p2_pc) + SumBits'(p2_pd) + RoundBias;
    q   = QBits'(sum >>> FracBits);
    priority if (q > QMax) begin
      y_sat = SampleMax;
    end else if (q < QMin) begin
      y_sat = SampleMin;
    end else begin
      y_sat = sample_t'(q);
    end
  end

  assign wr.en      = p2_move;
  assign wr.addr    = addr_t'(p2_ch);
  assign wr.data.y1 = y_sat;
  assign wr.data.y2 = p2_y1;
  assign wr.data.u1 = p2_u;
  assign wr.data.u2 = p2_u1;

  always_ff @(posedge clk) begin
    if (rst) begin
      p1_valid <= 1'b0;
      p2_valid <= 1'b0;
      o_valid  <= 1'b0;
    end else begin
      if (p1_free) begin
        p1_valid <= accept;
      end
      if (p2_free) begin
        p2_valid <= p1_valid;
      end
      if (o_free) begin
        o_valid <= p2_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      p1_ch <= in_ch;
      p1_u  <= in_sample;
    end
    if (p1_move) begin
      p2_ch <= p1_ch;
      p2_u  <= p1_u;
      p2_y1 <= hist.y1;
      p2_u1 <= hist.u1;
      p2_pa <= coef.a * hist.y1;
      p2_pb <= coef.b * hist.y2;
      p2_pc <= coef.c * p1_u;
      p2_pd <= coef.d * hist.u2;
    end
    if (p2_move) begin
      o_ch <= p2_ch;
      o_y  <= y_sat;
    end
  end

  assign out_valid  = o_valid;
  assign out_ch     = o_ch;
  assign out_sample = o_y;

endmodule

/* rtl/sois_checker.sv */
`timescale 1ns / 1ps

module sois_checker
  import sois_pkg::*;
(
  input logic                    clk,
  input logic                    rst,
  input logic                    s_tvalid,
  input logic                    s_tready,
  input logic [ChBits-1:0]       s_tuser,
  input logic                    m_tvalid,
  input logic                    m_tready,
  input logic [SampleBits-1:0]   m_tdata,
  input logic [ChBits-1:0]       m_tuser,
  input logic                    cfg_ready
);

  logic s_acc;
  assign s_acc = s_tvalid && s_tready;

  a_reset_empty: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("output valid right after reset");

  a_no_ready_in_reset: assert property (@(posedge clk) rst |-> !s_tready && !cfg_ready)
    else $error("ready during reset");

  // a channel's next request is never accepted back to back with its previous one
  a_same_ch_spacing: assert property (@(posedge clk) disable iff (rst)
    s_acc |-> !($past(s_acc) && $past(s_tuser) == s_tuser))
    else $error("same channel requests accepted back to back");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("stalled output changed");

endmodule

bind second_order_iir_section sois_checker u_sois_checker (.*);

/* sim/tb_top.sv */
`timescale 1ns / 1ps

module tb_top;
  import sois_pkg::*;

  typedef enum {ROW_CFG, ROW_SAMPLE} row_kind_t;

  typedef struct {
    row_kind_t   kind;
    cfg_index_t  reg_sel;
    logic [15:0] value;
    logic        ch;
    bit          typed;
    sample_t     want;
  } stim_row_t;

  typedef struct {
    logic    ch;
    sample_t smp;
  } filtered_t;

  logic                    clk = 1'b0;
  logic                    rst = 1'b1;
  logic                    s_tvalid = 1'b0;
  logic                    s_tready;
  logic [SampleBits-1:0]   s_tdata = '0;
  logic [ChBits-1:0]       s_tuser = '0;
  logic                    m_tvalid;
  logic                    m_tready = 1'b0;
  logic [SampleBits-1:0]   m_tdata;
  logic [ChBits-1:0]       m_tuser;
  logic                    cfg_valid = 1'b0;
  logic                    cfg_ready;
  logic [CfgIndexBits-1:0] cfg_index = '0;
  logic [CoefBits-1:0]     cfg_data = '0;

  logic signed [CoefBits-1:0] k_a, k_b, k_c, k_d;
  sample_t    y1 [Channels];
  sample_t    y2 [Channels];
  sample_t    u1 [Channels];
  sample_t    u2 [Channels];
  filtered_t  expected_samples [$];
  filtered_t  oldest;
  stim_row_t  rows [$];
  int         mismatches = 0;
  int         in_idle_pct = 35;
  int         out_idle_pct = 35;

  second_order_iir_section DUT (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #2 clk = ~clk;

  initial begin
    #2_000_000;
    $display("[second_order_iir_section] ERROR");
    $finish;
  end

  task automatic report_mismatch(input string msg);
    $display("%0t ns mismatch: %s", $time, msg);
    mismatches++;
  endtask

  // one step of the filter on the channel history, exact sum, round half up, saturate
  function automatic sample_t iir_predict(input logic ch, input sample_t u);
    longint acc;
    longint q;
    acc = longint'(k_a) * longint'(y1[ch]) + longint'(k_b) * longint'(y2[ch])
        + longint'(k_c) * longint'(u) + longint'(k_d) * longint'(u2[ch]);
    q = (acc + 64'sd8192) >>> FracBits;
    if (q > 32767) q = 32767;
    else if (q < -32768) q = -32768;
    y2[ch] = y1[ch];
    y1[ch] = sample_t'(q);
    u2[ch] = u1[ch];
    u1[ch] = u;
    return sample_t'(q);
  endfunction

  task automatic send_sample(input logic ch, input logic [15:0] smp, input bit typed,
                             input sample_t want);
    filtered_t item;
    sample_t   predicted;
    while (in_idle_pct != 0 && $urandom_range(99) < in_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= smp;
    s_tuser  <= ch;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    predicted = iir_predict(ch, sample_t'(smp));
    item.ch  = ch;
    item.smp = typed ? want : predicted;
    expected_samples.push_back(item);
  endtask

  // coefficients change only with the filter drained
  task automatic write_coef(input cfg_index_t reg_sel, input logic [15:0] value);
    s_tvalid <= 1'b0;
    while (expected_samples.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= reg_sel;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    case (reg_sel)
      CFG_COEF_A: k_a = value;
      CFG_COEF_B: k_b = value;
      CFG_COEF_C: k_c = value;
      CFG_COEF_D: k_d = value;
      default: ;
    endcase
  endtask

  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        if (expected_samples.size() == 0) begin
          report_mismatch($sformatf("unexpected result ch %0d sample %h", m_tuser, m_tdata));
        end else begin
          oldest = expected_samples.pop_front();
          if (m_tuser[0] !== oldest.ch)
            report_mismatch($sformatf("channel %0d, want %0d", m_tuser, oldest.ch));
          if (m_tdata !== oldest.smp)
            report_mismatch($sformatf("ch %0d sample %h, want %h", oldest.ch, m_tdata,
                                      oldest.smp));
        end
      end
      m_tready <= ($urandom_range(99) >= out_idle_pct);
    end
  end

  initial begin
    logic [15:0] phase_coef [4];
    logic [15:0] smp;
    k_a = '0;
    k_b = '0;
    k_c = '0;
    k_d = '0;
    for (int i = 0; i < Channels; i++) begin
      y1[i] = '0;
      y2[i] = '0;
      u1[i] = '0;
      u2[i] = '0;
    end

    // zero coefficients after reset
    rows.push_back('{ROW_SAMPLE, CFG_COEF_A, 16'h7fff, 1'b0, 1'b1, 16'sh0000});
    rows.push_back('{ROW_SAMPLE, CFG_COEF_A, 16'h8000, 1'b1, 1'b1, 16'sh0000});
    // unity gain on the current input
    rows.push_back('{ROW_CFG,    CFG_COEF_C, 16'h4000, 1'b0, 1'b0, 16'sh0000});
    rows.push_back('{ROW_SAMPLE, CFG_COEF_A, 16'h7fff, 1'b0, 1'b1, 16'sh7fff});
    rows.push_back('{ROW_SAMPLE, CFG_COEF_A, 16'h8000, 1'b1, 1'b1, 16'sh8000});
    rows.push_back('{ROW_SAMPLE, CFG_COEF_A, 16'h0000, 1'b0, 1'b1, 16'sh0000});
    // gain -2: saturation both ways
    rows.push_back('{ROW_CFG,    CFG_COEF_C, 16'h8000, 1'b0, 1'b0, 16'sh0000});
    rows.push_back('{ROW_SAMPLE, CFG_COEF_A, 16'h8000, 1'b0, 1'b1, 16'sh7fff});
    rows.push_back('{ROW_SAMPLE, CFG_COEF_A, 16'h7fff, 1'b1, 1'b1, 16'sh8000});
    // tiny gain: rounding, ties go up
    rows.push_back('{ROW_CFG,    CFG_COEF_C, 16'h0001, 1'b0, 1'b0, 16'sh0000});
    rows.push_back('{ROW_SAMPLE, CFG_COEF_A, 16'h2000, 1'b0, 1'b1, 16'sh0001});
    rows.push_back('{ROW_SAMPLE, CFG_COEF_A, 16'he000, 1'b1, 1'b1, 16'sh0000});
    rows.push_back('{ROW_SAMPLE, CFG_COEF_A, 16'hdfff, 1'b0, 1'b1, 16'shffff});
    rows.push_back('{ROW_SAMPLE, CFG_COEF_A, 16'h1fff, 1'b1, 1'b1, 16'sh0000});
    // extreme feedback and delayed input, history carried through
    rows.push_back('{ROW_CFG,    CFG_COEF_A, 16'h7fff, 1'b0, 1'b0, 16'sh0000});
    rows.push_back('{ROW_CFG,    CFG_COEF_B, 16'h8000, 1'b0, 1'b0, 16'sh0000});
    rows.push_back('{ROW_CFG,    CFG_COEF_C, 16'h4000, 1'b0, 1'b0, 16'sh0000});
    rows.push_back('{ROW_CFG,    CFG_COEF_D, 16'h7fff, 1'b0, 1'b0, 16'sh0000});
    rows.push_back('{ROW_SAMPLE, CFG_COEF_A, 16'h7fff, 1'b0, 1'b0, 16'sh0000});
    rows.push_back('{ROW_SAMPLE, CFG_COEF_A, 16'h8000, 1'b0, 1'b0, 16'sh0000});
    rows.push_back('{ROW_SAMPLE, CFG_COEF_A, 16'h7fff, 1'b1, 1'b0, 16'sh0000});
    rows.push_back('{ROW_SAMPLE, CFG_COEF_A, 16'h0000, 1'b0, 1'b0, 16'sh0000});
    rows.push_back('{ROW_SAMPLE, CFG_COEF_A, 16'h8000, 1'b1, 1'b0, 16'sh0000});
    rows.push_back('{ROW_SAMPLE, CFG_COEF_A, 16'h0001, 1'b1, 1'b0, 16'sh0000});

    repeat (6) @(posedge clk);
    rst <= 1'b0;

    foreach (rows[r]) begin
      if (rows[r].kind == ROW_CFG)
        write_coef(rows[r].reg_sel, rows[r].value);
      else
        send_sample(rows[r].ch, rows[r].value, rows[r].typed, rows[r].want);
    end

    for (int p = 0; p < 9; p++) begin
      case (p)
        0: phase_coef = '{16'd26214, 16'hc63d, 16'd819, 16'hfccd};
        1: phase_coef = '{16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff};
        2: phase_coef = '{16'h8000, 16'h8000, 16'h8000, 16'h8000};
        3: phase_coef = '{16'h0000, 16'h0000, 16'h4000, 16'h0000};
        default: begin
          for (int i = 0; i < 4; i++) phase_coef[i] = 16'($urandom);
        end
      endcase
      for (int i = 0; i < 4; i++) write_coef(cfg_index_t'(i), phase_coef[i]);
      in_idle_pct  = (p == 4) ? 0 : 35;
      out_idle_pct = (p == 4) ? 0 : 35;
      for (int n = 0; n < 185; n++) begin
        if ($urandom_range(99) < 15) begin
          case ($urandom_range(3))
            0: smp = 16'h7fff;
            1: smp = 16'h8000;
            2: smp = 16'h0000;
            default: smp = 16'hffff;
          endcase
        end else begin
          smp = 16'($urandom);
        end
        send_sample(1'($urandom_range(1)), smp, 1'b0, '0);
      end
    end

    s_tvalid <= 1'b0;
    while (expected_samples.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (mismatches == 0) begin
      $display("[second_order_iir_section] OK");
    end else begin
      $display("[second_order_iir_section] ERROR");
    end
    $finish;
  end

endmodule

/* filelist.f */
rtl/sois_pkg.sv
rtl/sois_hist_ram.sv
rtl/sois_datapath.sv
rtl/second_order_iir_section.sv
rtl/sois_checker.sv
sim/tb_top.sv
